// File: sv/cgnw_pkg.sv
`default_nettype none

package cgnw_pkg;

  localparam int COORD_BITS = 10;
  localparam int STEP_BITS  = 16;
  localparam int LIN_BITS   = 30;
  localparam int EDGE_BITS  = 11;
  localparam int SY_BITS    = 21;
  localparam int SZ_BITS    = 31;
  localparam int DIMS_BITS  = 2;
  localparam int CNT_BITS   = 4;
  localparam int OP_BITS    = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 31;
  // wide enough for a coordinate plus one and for an edge length
  localparam int CMP_BITS = (COORD_BITS + 1 > EDGE_BITS) ? COORD_BITS + 1 : EDGE_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [EDGE_BITS-1:0]  edge_t;
  typedef logic [LIN_BITS-1:0]   lin_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_SET_START  = 3'd0,
    OP_SET_CUR    = 3'd1,
    OP_BACK_START = 3'd2,
    OP_FORWARD    = 3'd3,
    OP_BACKWARD   = 3'd4,
    OP_NEXT_NBR   = 3'd5,
    OP_REWIND     = 3'd6
  } op_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_X   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_Y   = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_Z   = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE_Y = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE_Z = CFG_IDX_BITS'(5);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_SCAN,
    S_MUL,
    S_SUM,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic scan;
    logic mul;
    logic sum;
  } ctl_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic ok;
    logic scan_end;
    logic scan_hit;
  } dp_stat_t;

  // one half-shell offset, -1..1 per axis
  typedef struct packed {
    logic signed [1:0] z;
    logic signed [1:0] y;
    logic signed [1:0] x;
  } off_t;

  function automatic off_t shell_off(input cnt_t k);
    off_t o;
    o = '0;
    case (k)
      4'd0:  o = '{z: 2'sd0, y:  2'sd0, x:  2'sd0};
      4'd1:  o = '{z: 2'sd0, y:  2'sd0, x:  2'sd1};
      4'd2:  o = '{z: 2'sd0, y:  2'sd1, x:  2'sd1};
      4'd3:  o = '{z: 2'sd0, y:  2'sd1, x:  2'sd0};
      4'd4:  o = '{z: 2'sd0, y:  2'sd1, x: -2'sd1};
      4'd5:  o = '{z: 2'sd1, y:  2'sd0, x:  2'sd0};
      4'd6:  o = '{z: 2'sd1, y:  2'sd0, x:  2'sd1};
      4'd7:  o = '{z: 2'sd1, y:  2'sd1, x:  2'sd1};
      4'd8:  o = '{z: 2'sd1, y:  2'sd1, x:  2'sd0};
      4'd9:  o = '{z: 2'sd1, y:  2'sd1, x: -2'sd1};
      4'd10: o = '{z: 2'sd1, y:  2'sd0, x: -2'sd1};
      4'd11: o = '{z: 2'sd1, y: -2'sd1, x: -2'sd1};
      4'd12: o = '{z: 2'sd1, y: -2'sd1, x:  2'sd0};
      4'd13: o = '{z: 2'sd1, y: -2'sd1, x:  2'sd1};
      default: o = '0;
    endcase
    return o;
  endfunction

  // table length for the configured dimension count (zero acts as one)
  function automatic cnt_t shell_len(input logic [DIMS_BITS-1:0] d);
    cnt_t n;
    case (d)
      2'd2:    n = CNT_BITS'(5);
      2'd3:    n = CNT_BITS'(14);
      default: n = CNT_BITS'(2);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/cgnw_ctrl.sv
`default_nettype none

module cgnw_ctrl
  import cgnw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [OP_BITS-1:0] op,
  input  wire dp_stat_t           stat,
  output ctl_cmd_t                cmd,
  output logic                    busy,
  output logic                    done,
  output logic                    cfg_ready
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op_t'(op))
            OP_SET_START, OP_SET_CUR: state_next = S_MUL;
            OP_FORWARD, OP_BACKWARD:  state_next = S_STEP;
            OP_NEXT_NBR:              state_next = S_SCAN;
            default:                  state_next = S_DONE;
          endcase
        end
      end
      S_STEP: begin
        if (stat.steps_zero || !stat.ok) state_next = S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_end) state_next = S_DONE;
        else if (stat.scan_hit) state_next = S_MUL;
      end
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load = start;
      S_STEP: cmd.step = !stat.steps_zero && stat.ok;
      S_SCAN: cmd.scan = !stat.scan_end;
      S_MUL:  cmd.mul  = 1'b1;
      S_SUM:  cmd.sum  = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = (state == S_IDLE);

endmodule

`default_nettype wire

// File: sv/cgnw_dp.sv
`default_nettype none

module cgnw_dp
  import cgnw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctl_cmd_t                 cmd,
  output dp_stat_t                      stat,
  input  wire logic [OP_BITS-1:0]       op,
  input  wire logic [COORD_BITS-1:0]    coord_x,
  input  wire logic [COORD_BITS-1:0]    coord_y,
  input  wire logic [COORD_BITS-1:0]    coord_z,
  input  wire logic [STEP_BITS-1:0]     steps,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic [COORD_BITS-1:0]         cur_x,
  output logic [COORD_BITS-1:0]         cur_y,
  output logic [COORD_BITS-1:0]         cur_z,
  output logic [LIN_BITS-1:0]           cur_index,
  output logic [COORD_BITS-1:0]         nbr_x,
  output logic [COORD_BITS-1:0]         nbr_y,
  output logic [COORD_BITS-1:0]         nbr_z,
  output logic [LIN_BITS-1:0]           nbr_index,
  output logic                          ok,
  output logic [CNT_BITS-1:0]           nbr_slot
);

  // configuration
  logic [DIMS_BITS-1:0] dims;
  edge_t                edge_len [3];
  logic [SY_BITS-1:0]   stride_y;
  logic [SZ_BITS-1:0]   stride_z;

  // architectural state
  coord_t cur [3];
  coord_t sta [3];
  coord_t nbr [3];
  lin_t   cur_lin, sta_lin, nbr_lin;
  cnt_t   nbr_cnt;
  logic   ok_flag;

  // per-operation working registers
  op_t                  op_q;
  logic [STEP_BITS-1:0] steps_left;
  coord_t               cand [3];
  lin_t                 prod_y, prod_z;

  logic [DIMS_BITS-1:0] used_dims;
  coord_t fwd_cell [3];
  coord_t back_cell [3];
  coord_t scan_cell [3];
  logic   fwd_ok, back_ok, scan_in;
  off_t   off;
  logic [1:0] off_v [3];
  lin_t   lin_sum;

  assign used_dims = (dims == '0) ? DIMS_BITS'(1) : dims;

  // one forward cell step: increment with carry up the used axes
  always_comb begin
    cmp_t inc;
    logic carry;
    carry  = 1'b1;
    fwd_ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fwd_cell[i] = cur[i];
      inc = cmp_t'(cur[i]) + cmp_t'(1);
      if (carry && (DIMS_BITS'(i) < used_dims)) begin
        if (inc == cmp_t'(edge_len[i])) begin
          fwd_cell[i] = '0;
        end else begin
          fwd_cell[i] = inc[COORD_BITS-1:0];
          fwd_ok = 1'b1;
          carry  = 1'b0;
        end
      end
    end
  end

  // one backward cell step: borrow reloads edge minus one
  always_comb begin
    cmp_t top;
    logic borrow;
    borrow  = 1'b1;
    back_ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      back_cell[i] = cur[i];
      top = cmp_t'(edge_len[i]) - cmp_t'(1);
      if (borrow && (DIMS_BITS'(i) < used_dims)) begin
        if (cur[i] == '0) begin
          back_cell[i] = top[COORD_BITS-1:0];
        end else begin
          back_cell[i] = cur[i] - COORD_BITS'(1);
          back_ok = 1'b1;
          borrow  = 1'b0;
        end
      end
    end
  end

  // candidate neighbor for the current table slot
  assign off      = shell_off(nbr_cnt);
  assign off_v[0] = off.x;
  assign off_v[1] = off.y;
  assign off_v[2] = off.z;

  always_comb begin
    cmp_t v;
    logic neg;
    scan_in = 1'b1;
    for (int i = 0; i < 3; i++) begin
      neg = (cur[i] == '0) && (off_v[i] == 2'b11);
      v = cmp_t'(cur[i]) + {{(CMP_BITS-2){off_v[i][1]}}, off_v[i]};
      scan_cell[i] = v[COORD_BITS-1:0];
      if ((DIMS_BITS'(i) < used_dims) && (neg || (v >= cmp_t'(edge_len[i])))) begin
        scan_in = 1'b0;
      end
    end
  end

  assign lin_sum = lin_t'(cand[0]) + prod_y + prod_z;

  assign stat.steps_zero = (steps_left == '0);
  assign stat.ok         = ok_flag;
  assign stat.scan_end   = (nbr_cnt >= shell_len(dims));
  assign stat.scan_hit   = scan_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims        <= DIMS_BITS'(3);
      edge_len[0] <= EDGE_BITS'(1);
      edge_len[1] <= EDGE_BITS'(1);
      edge_len[2] <= EDGE_BITS'(1);
      stride_y    <= SY_BITS'(1);
      stride_z    <= SZ_BITS'(1);
      for (int i = 0; i < 3; i++) begin
        cur[i] <= '0;
        sta[i] <= '0;
        nbr[i] <= '0;
      end
      cur_lin <= '0;
      sta_lin <= '0;
      nbr_lin <= '0;
      nbr_cnt <= '0;
      ok_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIMS:     dims        <= cfg_data[DIMS_BITS-1:0];
          CFG_EDGE_X:   edge_len[0] <= cfg_data[EDGE_BITS-1:0];
          CFG_EDGE_Y:   edge_len[1] <= cfg_data[EDGE_BITS-1:0];
          CFG_EDGE_Z:   edge_len[2] <= cfg_data[EDGE_BITS-1:0];
          CFG_STRIDE_Y: stride_y    <= cfg_data[SY_BITS-1:0];
          CFG_STRIDE_Z: stride_z    <= cfg_data[SZ_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        case (op_t'(op))
          OP_SET_START, OP_SET_CUR: begin
            nbr_cnt <= '0;
            ok_flag <= 1'b1;
          end
          OP_BACK_START: begin
            for (int i = 0; i < 3; i++) begin
              cur[i] <= sta[i];
              nbr[i] <= sta[i];
            end
            cur_lin <= sta_lin;
            nbr_lin <= sta_lin;
            nbr_cnt <= '0;
            ok_flag <= 1'b1;
          end
          OP_FORWARD, OP_BACKWARD: ok_flag <= 1'b1;
          OP_NEXT_NBR:             ok_flag <= 1'b0;
          OP_REWIND: begin
            for (int i = 0; i < 3; i++) nbr[i] <= cur[i];
            nbr_lin <= cur_lin;
            nbr_cnt <= '0;
            ok_flag <= 1'b1;
          end
          default: ok_flag <= 1'b0;
        endcase
      end

      if (cmd.step) begin
        nbr_cnt <= '0;
        if (op_q == OP_FORWARD) begin
          for (int i = 0; i < 3; i++) cur[i] <= fwd_cell[i];
          cur_lin <= cur_lin + LIN_BITS'(1);
          nbr_lin <= nbr_lin + LIN_BITS'(1);
          ok_flag <= fwd_ok;
        end else begin
          for (int i = 0; i < 3; i++) cur[i] <= back_cell[i];
          cur_lin <= cur_lin - LIN_BITS'(1);
          nbr_lin <= nbr_lin - LIN_BITS'(1);
          ok_flag <= back_ok;
        end
      end

      if (cmd.scan) begin
        nbr_cnt <= nbr_cnt + CNT_BITS'(1);
        if (scan_in) ok_flag <= 1'b1;
      end

      if (cmd.sum) begin
        case (op_q)
          OP_SET_START: begin
            for (int i = 0; i < 3; i++) begin
              sta[i] <= cand[i];
              cur[i] <= cand[i];
              nbr[i] <= cand[i];
            end
            sta_lin <= lin_sum;
            cur_lin <= lin_sum;
            nbr_lin <= lin_sum;
          end
          OP_SET_CUR: begin
            for (int i = 0; i < 3; i++) begin
              cur[i] <= cand[i];
              nbr[i] <= cand[i];
            end
            cur_lin <= lin_sum;
            nbr_lin <= lin_sum;
          end
          default: begin
            for (int i = 0; i < 3; i++) nbr[i] <= cand[i];
            nbr_lin <= lin_sum;
          end
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= op_t'(op);
      steps_left <= steps;
      cand[0]    <= coord_x;
      cand[1]    <= coord_y;
      cand[2]    <= coord_z;
    end
    if (cmd.step) begin
      steps_left <= steps_left - STEP_BITS'(1);
    end
    if (cmd.scan && scan_in) begin
      for (int i = 0; i < 3; i++) cand[i] <= scan_cell[i];
    end
    if (cmd.mul) begin
      prod_y <= (used_dims >= DIMS_BITS'(2)) ? lin_t'(cand[1]) * lin_t'(stride_y) : '0;
      prod_z <= (used_dims >= DIMS_BITS'(3)) ? lin_t'(cand[2]) * lin_t'(stride_z) : '0;
    end
  end

  assign cur_x     = cur[0];
  assign cur_y     = cur[1];
  assign cur_z     = cur[2];
  assign cur_index = cur_lin;
  assign nbr_x     = nbr[0];
  assign nbr_y     = nbr[1];
  assign nbr_z     = nbr[2];
  assign nbr_index = nbr_lin;
  assign ok        = ok_flag;
  assign nbr_slot  = nbr_cnt;

endmodule

`default_nettype wire

// File: sv/cell_grid_neighbor_walker_core.sv
`default_nettype none

// Cell grid cursor: current, start and neighbor cells over a 1-D to 3-D grid.
// Command channel: an op with its coordinates and step count transfers on a
//   clock edge with start high and busy low. busy stays high until the result.
// Result channel: done pulses for one cycle; cur_*, nbr_*, ok and nbr_slot
//   are valid in that cycle. The receiver cannot stall; a result is taken as
//   the done cycle ends. The next command transfers at the earliest in the
//   cycle after done.
// Sequence from command transfer to done:
//   back to start, rewind, unused op:   straight to done
//   set start / set current:            multiply, then sum for index, then done
//   forward / backward by n cells:      step loop, one cell per cycle, then done;
//                                       the loop ends early if the walk leaves grid
//   next neighbor:                      scan of table slots in order; on a hit,
//                                       index multiply and sum; at most 14 slots tried
// Config channel: cfg_index / cfg_data transfer when cfg_valid and cfg_ready;
//   ready is high only while idle. Registers: dims, edges x/y/z, strides y/z.
// Reset: dims 3, edges and strides 1, all cells and indices zero, slot zero.

module cell_grid_neighbor_walker_core
  import cgnw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // command
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_BITS-1:0]       op,
  input  wire logic [COORD_BITS-1:0]    coord_x,
  input  wire logic [COORD_BITS-1:0]    coord_y,
  input  wire logic [COORD_BITS-1:0]    coord_z,
  input  wire logic [STEP_BITS-1:0]     steps,
  // result
  output logic                          done,
  output logic [COORD_BITS-1:0]         cur_x,
  output logic [COORD_BITS-1:0]         cur_y,
  output logic [COORD_BITS-1:0]         cur_z,
  output logic [LIN_BITS-1:0]           cur_index,
  output logic [COORD_BITS-1:0]         nbr_x,
  output logic [COORD_BITS-1:0]         nbr_y,
  output logic [COORD_BITS-1:0]         nbr_z,
  output logic [LIN_BITS-1:0]           nbr_index,
  output logic                          ok,
  output logic [CNT_BITS-1:0]           nbr_slot,
  // configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  ctl_cmd_t cmd;    // controller -> datapath strobes
  dp_stat_t stat;   // datapath -> controller status
  logic     cfg_we;

  // a config transfer; the controller only raises ready while idle
  assign cfg_we = cfg_valid & cfg_ready;

  // sequencer: load, step loop, neighbor scan, index multiply/sum, done pulse
  cgnw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
  );

  // cell registers, carry/borrow step, offset table test, stride multipliers
  cgnw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .steps     (steps),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cur_z     (cur_z),
    .cur_index (cur_index),
    .nbr_x     (nbr_x),
    .nbr_y     (nbr_y),
    .nbr_z     (nbr_z),
    .nbr_index (nbr_index),
    .ok        (ok),
    .nbr_slot  (nbr_slot)
  );

endmodule

`default_nettype wire
